>>> hw/rtl/ksc_pkg.sv
// shared types, constants and helpers for the keyword substitution cipher unit
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package ksc_pkg;

    localparam int LETTERS  = 26;
    localparam int LETTER_W = 5;
    localparam logic [7:0] CODE_A       = 8'h41;
    localparam logic [7:0] CODE_Z       = 8'h5A;
    localparam logic [7:0] CODE_LOWER_A = 8'h61;
    localparam logic [7:0] CODE_LOWER_Z = 8'h7A;
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);
    localparam logic [LETTER_W-1:0] FULL_COUNT  = LETTER_W'(LETTERS);

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_CLEAR    = 2'd0,
        REQ_KEYWORD  = 2'd1,
        REQ_FINALIZE = 2'd2,
        REQ_PLAIN    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LOOKUP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic keyword;
        logic fin_start;
        logic sweep_step;
        logic lookup;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic ready;
        logic sweep_last;
        logic out_busy;
    } stat_t;

    // letter code of a byte: bit 5 set for ascii letters, low bits the index 0..25
    function automatic logic [LETTER_W:0] letter_code(input logic [7:0] b);
        logic [7:0] diff;
        logic [LETTER_W:0] res;
        res = '0;
        diff = 8'h00;
        if (b >= CODE_A && b <= CODE_Z)
        begin
            diff = b - CODE_A;
            res = {1'b1, diff[LETTER_W-1:0]};
        end
        else if (b >= CODE_LOWER_A && b <= CODE_LOWER_Z)
        begin
            diff = b - CODE_LOWER_A;
            res = {1'b1, diff[LETTER_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ksc_ctrl.sv
// controller state machine for the keyword substitution cipher unit
// depends on ksc_pkg; drives datapath commands from request kind and status
`default_nettype none

module ksc_ctrl
    import ksc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] req_kind,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    req_t   req;

    assign req    = req_t'(req_kind);
    assign accept = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req == REQ_FINALIZE && !stat.ready)
                begin
                    state_next = ST_SWEEP;
                end
                else if (accept && req == REQ_PLAIN)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.clear     = accept && req == REQ_CLEAR;
                cmd.keyword   = accept && req == REQ_KEYWORD;
                cmd.fin_start = accept && req == REQ_FINALIZE && !stat.ready;
                cmd.lookup    = accept && req == REQ_PLAIN;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ksc_datapath.sv
// datapath: used-letter map, cipher alphabet memory, fill count, sweep counter
// and output register; depends on ksc_pkg, driven by ksc_ctrl commands
`default_nettype none

module ksc_datapath
    import ksc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire logic [7:0] char_in,
    input  wire logic       out_ready,
    output stat_t           stat,
    output logic            out_valid,
    output logic [7:0]      char_out,
    output logic            not_ready
);

    logic [LETTERS-1:0]  used_reg, used_next;
    logic [LETTER_W-1:0] fill_reg, fill_next;
    logic                ready_reg, ready_next;
    logic [LETTER_W-1:0] k_reg, k_next;

    logic [LETTER_W-1:0] alpha_mem [LETTERS];
    logic [LETTER_W-1:0] rd_data_reg;
    logic                wr_en;
    logic [LETTER_W-1:0] wr_data;

    logic [7:0]          ch_reg;
    logic                letter_reg;
    logic                pend_nr_reg;

    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic                out_nr_reg;

    logic [LETTER_W:0]   code;
    logic                in_letter;
    logic [LETTER_W-1:0] in_idx;
    logic [7:0]          enc_char;

    assign code      = letter_code(char_in);
    assign in_letter = code[LETTER_W];
    assign in_idx    = code[LETTER_W-1:0];

    // alphabet build: clear, keyword append and finalize sweep
    always_comb
    begin
        used_next  = used_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        k_next     = k_reg;
        wr_en      = 1'b0;
        wr_data    = in_idx;
        if (cmd.clear)
        begin
            used_next  = '0;
            fill_next  = '0;
            ready_next = 1'b0;
        end
        else if (cmd.keyword)
        begin
            if (!ready_reg && in_letter && !used_reg[in_idx])
            begin
                used_next[in_idx] = 1'b1;
                if (fill_reg < FULL_COUNT)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
        else if (cmd.fin_start)
        begin
            k_next = '0;
        end
        else if (cmd.sweep_step)
        begin
            wr_data = k_reg;
            if (!used_reg[k_reg])
            begin
                used_next[k_reg] = 1'b1;
                if (fill_reg < FULL_COUNT)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            k_next = k_reg + 1'b1;
            if (k_reg == LAST_LETTER)
            begin
                ready_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
            k_reg     <= k_next;
        end
    end

    // alphabet memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            alpha_mem[fill_reg] <= wr_data;
        end
        if (cmd.lookup && ready_reg && in_letter)
        begin
            rd_data_reg <= alpha_mem[in_idx];
        end
    end

    // plaintext beat held during the lookup
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            ch_reg      <= char_in;
            letter_reg  <= in_letter;
            pend_nr_reg <= !ready_reg;
        end
    end

    assign enc_char = (letter_reg && !pend_nr_reg) ? (CODE_A + 8'(rd_data_reg)) : ch_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_char_reg <= enc_char;
            out_nr_reg   <= pend_nr_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign char_out        = out_char_reg;
    assign not_ready       = out_nr_reg;
    assign stat.ready      = ready_reg;
    assign stat.sweep_last = k_reg == LAST_LETTER;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // a finalized alphabet is always full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fill_reg == FULL_COUNT && (&used_reg)))
        else $error("finalized alphabet not full");

    // each used letter owns exactly one alphabet entry
    a_fill_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(fill_reg))
        else $error("fill count out of step with used-letter map");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ready))
        else $error("output register overwritten while stalled");

    // the sweep ends in a finalized alphabet
    a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_step && k_reg == LAST_LETTER) |=> ready_reg)
        else $error("sweep finished without finalizing");

endmodule

`default_nettype wire

>>> hw/rtl/keyword_substitution_cipher_unit.sv
// keyword substitution cipher unit: clear and keyword beats are taken in the idle state
// finalize, unless already finalized, runs a sweep over A..Z in the datapath, input stalled meanwhile
// plaintext: registered alphabet read then output register; the input is stalled until
// the result is loaded, and the load waits while the output is not taken
// rst_n (async, active low) clears the used-letter map, fill count, ready flag,
// state machine and output valid; alphabet entries are not cleared
`default_nettype none

module keyword_substitution_cipher_unit
    import ksc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic [1:0] s_axis_tuser,   // [1:0] req_type
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] char_out
    output logic [0:0]      m_axis_tuser    // [0] not_ready
);

    cmd_t  cmd;
    stat_t stat;

    ksc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .req_kind (s_axis_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    ksc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_in   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .char_out  (m_axis_tdata),
        .not_ready (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_keyword_substitution_cipher_unit.sv
// self-checking testbench for the keyword substitution cipher unit: random and directed
// clear, keyword, finalize and plaintext beats checked against an in-bench cipher predictor
// depends on ksc_pkg (hw/rtl/ksc_pkg.sv) and keyword_substitution_cipher_unit
module tb_keyword_substitution_cipher_unit
    import ksc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one request beat on the input stream
    typedef struct packed {
        req_t       kind;
        logic [7:0] ch;
    } cipher_req_t;

    // one enciphered byte on the output stream
    typedef struct packed {
        logic [7:0] ch;
        logic       not_ready;
    } cipher_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
    logic [1:0] s_axis_tuser = REQ_CLEAR;   // [1:0] req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [7:0] char_out
    logic [0:0] m_axis_tuser;   // [0] not_ready

    // request beats waiting to be sent and enciphered bytes still owed by the block
    cipher_req_t  req_backlog[$];
    cipher_byte_t enciphered_q[$];

    // predictor copy of the keyword alphabet
    logic [LETTERS-1:0]  key_used = '0;
    logic [LETTER_W-1:0] key_alpha [LETTERS];
    logic [LETTER_W-1:0] key_fill = '0;
    logic                key_ready = 1'b0;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int   errors = 0;
    int   n_beats = 0;
    int   n_results = 0;
    int   n_early = 0;

    keyword_substitution_cipher_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // alphabet position of an ascii letter, -1 for anything else
    function automatic int letter_pos(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A)
            return int'(b) - 'h41;
        if (b >= 8'h61 && b <= 8'h7A)
            return int'(b) - 'h61;
        return -1;
    endfunction

    // append a letter to the predicted alphabet
    function automatic void key_append(input int pos);
        if (key_fill < FULL_COUNT)
        begin
            key_alpha[key_fill] = LETTER_W'(pos);
            key_fill = key_fill + 1'b1;
        end
        key_used[pos] = 1'b1;
    endfunction

    // sender: predicts each accepted beat, then offers the next one from the backlog
    always @(posedge clk or negedge rst_n)
    begin : sender
        cipher_req_t nxt;
        req_t        kind;
        int          pos;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= REQ_CLEAR;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_beats++;
                kind = req_t'(s_axis_tuser);
                pos = letter_pos(s_axis_tdata);
                case (kind)
                    REQ_CLEAR:
                    begin
                        key_used = '0;
                        key_fill = '0;
                        key_ready = 1'b0;
                    end
                    REQ_KEYWORD:
                    begin
                        // keyword bytes after finalize are dropped
                        if (!key_ready && pos >= 0 && !key_used[pos])
                            key_append(pos);
                    end
                    REQ_FINALIZE:
                    begin
                        if (!key_ready)
                        begin
                            for (int k = 0; k < LETTERS; k++)
                                if (!key_used[k])
                                    key_append(k);
                            key_ready = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!key_ready)
                            enciphered_q.push_back('{ch: s_axis_tdata, not_ready: 1'b1});
                        else if (pos >= 0)
                            enciphered_q.push_back('{ch: 8'h41 + 8'(key_alpha[pos]),
                                                     not_ready: 1'b0});
                        else
                            enciphered_q.push_back('{ch: s_axis_tdata, not_ready: 1'b0});
                    end
                endcase
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tuser  <= nxt.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready with random stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // long receiver hold-off, counted here while the sender keeps offering beats
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: compare each output beat with the oldest owed byte
    always @(posedge clk)
    begin : monitor
        cipher_byte_t owed;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (enciphered_q.size() == 0)
            begin
                $error("unexpected output beat: char_out %h not_ready %b",
                       m_axis_tdata, m_axis_tuser[0]);
                errors++;
            end
            else
            begin
                owed = enciphered_q.pop_front();
                n_results++;
                if (owed.not_ready)
                    n_early++;
                if (m_axis_tdata !== owed.ch)
                begin
                    $error("char_out: expected %h, got %h", owed.ch, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== owed.not_ready)
                begin
                    $error("not_ready: expected %b, got %b", owed.not_ready, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    task automatic push_req(input req_t kind, input logic [7:0] ch, inout int count);
        req_backlog.push_back('{kind: kind, ch: ch});
        count++;
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    // one keyword session with random content, or a burst of noise
    task automatic queue_session(inout int count);
        int r;
        r = $urandom_range(99);
        if (r < 82)
        begin
            push_req(REQ_CLEAR, 8'($urandom_range(255)), count);
            repeat ($urandom_range(10))
                push_req(REQ_KEYWORD, ($urandom_range(99) < 85) ? rand_letter()
                                                               : 8'($urandom_range(255)), count);
            if ($urandom_range(99) < 12)
                push_req(REQ_PLAIN, 8'($urandom_range(255)), count);
            push_req(REQ_FINALIZE, 8'($urandom_range(255)), count);
            if ($urandom_range(99) < 10)
                push_req(REQ_FINALIZE, 8'($urandom_range(255)), count);
            if ($urandom_range(99) < 10)
                push_req(REQ_KEYWORD, rand_letter(), count);
            repeat ($urandom_range(14, 3))
                push_req(REQ_PLAIN, ($urandom_range(99) < 80) ? rand_letter()
                                                             : 8'($urandom_range(255)), count);
        end
        else
        begin
            repeat ($urandom_range(6, 1))
                push_req(req_t'($urandom_range(3)), 8'($urandom_range(255)), count);
        end
    endtask

    // wait until every beat is sent and every owed byte has come back
    task automatic drain();
        while (req_backlog.size() != 0 || s_axis_tvalid || enciphered_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int target);
        int count;
        count = 0;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        while (count < target)
            queue_session(count);
        drain();
    endtask

    // stimulus
    initial
    begin : stimulus
        int n;
        n = 0;
        wait (rst_n);
        @(negedge clk);

        // directed: early plaintext, keyword edge bytes, double finalize, late keyword
        push_req(REQ_CLEAR, 8'h00, n);
        push_req(REQ_PLAIN, "a", n);
        push_req(REQ_PLAIN, 8'hFF, n);
        push_req(REQ_PLAIN, 8'h00, n);
        push_req(REQ_KEYWORD, "Z", n);
        push_req(REQ_KEYWORD, "z", n);
        push_req(REQ_KEYWORD, "a", n);
        push_req(REQ_KEYWORD, 8'h40, n);
        push_req(REQ_KEYWORD, 8'h5B, n);
        push_req(REQ_KEYWORD, 8'h60, n);
        push_req(REQ_KEYWORD, 8'h7B, n);
        push_req(REQ_KEYWORD, 8'h80, n);
        push_req(REQ_KEYWORD, "M", n);
        push_req(REQ_FINALIZE, 8'hFF, n);
        push_req(REQ_FINALIZE, 8'h00, n);
        push_req(REQ_KEYWORD, "Q", n);
        push_req(REQ_PLAIN, "A", n);
        push_req(REQ_PLAIN, "z", n);
        push_req(REQ_PLAIN, "Z", n);
        push_req(REQ_PLAIN, "a", n);
        push_req(REQ_PLAIN, "m", n);
        push_req(REQ_PLAIN, 8'h00, n);
        push_req(REQ_PLAIN, 8'hFF, n);
        push_req(REQ_PLAIN, 8'h40, n);
        push_req(REQ_PLAIN, 8'h7B, n);
        drain();

        // random phases: free-running, sparse sender, stalling receiver, both
        run_phase(0, 0, 90);
        run_phase(81, 0, 65);
        run_phase(0, 81, 65);
        run_phase(23, 23, 65);

        // back-pressure: receiver held off while the sender keeps pushing plaintext
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_go = 1'b1;
        push_req(REQ_CLEAR, 8'h00, n);
        repeat (6)
            push_req(REQ_KEYWORD, rand_letter(), n);
        push_req(REQ_FINALIZE, 8'h00, n);
        repeat (50)
            push_req(REQ_PLAIN, ($urandom_range(99) < 85) ? rand_letter()
                                                         : 8'($urandom_range(255)), n);
        drain();
        run_phase(0, 0, 20);

        // settle past a trailing finalize sweep and catch stray beats
        repeat (40) @(posedge clk);
        if (enciphered_q.size() != 0)
        begin
            $error("%0d enciphered bytes never arrived", enciphered_q.size());
            errors++;
        end
        $display("sent %0d request beats and checked %0d enciphered bytes, %0d before finalize",
                 n_beats, n_results, n_early);
        $display("traffic ran free, sparse, stalled, mixed and under a long output hold-off");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ksc_pkg.sv
hw/rtl/ksc_ctrl.sv
hw/rtl/ksc_datapath.sv
hw/rtl/keyword_substitution_cipher_unit.sv
tb/sv/tb_keyword_substitution_cipher_unit.sv
